>>> rtl/tmwg_pkg.sv
`default_nettype none

package tmwg_pkg;

   // Field widths of the request, result and register payloads
   localparam int AMP_W       = 12;
   localparam int MODE_W      = 2;
   localparam int DUTY_W      = 7;
   localparam int PHASE_OUT_W = 8;
   localparam int SINE_W      = 16;
   localparam int QUO_W       = 12;

   // Default period length in samples
   localparam int SAMPLES_PER_PERIOD_DEF = 200;

   // Duty is given in percent
   localparam int DUTY_MAX = 100;

   // Configuration port
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // Register indexes (paddr[3:2])
   localparam logic [1:0] REG_WAVE_MODE = 2'd0;
   localparam logic [1:0] REG_AMPLITUDE = 2'd1;
   localparam logic [1:0] REG_DUTY      = 2'd2;

   // Wave mode codes
   localparam logic [MODE_W-1:0] MODE_SQUARE   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SINE     = 2'd1;
   localparam logic [MODE_W-1:0] MODE_TRIANGLE = 2'd2;

   // Register reset values
   localparam logic [MODE_W-1:0] WAVE_MODE_RST = MODE_SQUARE;
   localparam logic [AMP_W-1:0]  AMPLITUDE_RST = 12'd3722;
   localparam logic [DUTY_W-1:0] DUTY_RST      = 7'd50;

endpackage

`default_nettype wire

>>> rtl/tmwg_channels.sv
`default_nettype none

// Request channel: one sample tick
interface tmwg_req_if;
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink   (input valid, input restart, output ready);
endinterface

// Result channel: one DAC sample
interface tmwg_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [tmwg_pkg::AMP_W-1:0]         dac_code;
   logic [tmwg_pkg::PHASE_OUT_W-1:0]   phase_index;
   logic                               period_last;

   modport source (output valid, output dac_code, output phase_index, output period_last,
                   input ready);
   modport sink   (input valid, input dac_code, input phase_index, input period_last,
                   output ready);
endinterface

`default_nettype wire

>>> rtl/tmwg_sine_rom.sv
`default_nettype none

module tmwg_sine_rom #(
   parameter int SAMPLES_PER_PERIOD = tmwg_pkg::SAMPLES_PER_PERIOD_DEF
) (
   input  wire logic                                  clock,
   input  wire logic [$clog2(SAMPLES_PER_PERIOD)-1:0] addr,
   output logic      [tmwg_pkg::SINE_W-1:0]           data
);

   localparam int AW = $clog2(SAMPLES_PER_PERIOD);
   localparam longint unsigned Q30_ONE     = 64'd1073741824;
   localparam longint unsigned Q30_HALF_PI = 64'd1686629713;
   localparam longint unsigned SINE_MID    = 64'd32768;
   localparam longint unsigned SINE_MAX    = 64'd32767;

   // Offset-binary sine code 32768 + round(32768 * sin(2*pi*idx/N)), built at elaboration
   // (term capped at 32767). Quadrant fold, degree-11 Taylor series in Q30 (Horner form).
   function automatic logic [tmwg_pkg::SINE_W-1:0] sine_offset(input int unsigned idx);
      longint unsigned q;
      longint unsigned quad;
      longint unsigned r;
      longint unsigned t;
      longint unsigned t2;
      longint unsigned h;
      longint unsigned s;
      begin
         q    = longint'(idx) * 4;
         quad = q / SAMPLES_PER_PERIOD;
         r    = q % SAMPLES_PER_PERIOD;
         if ((quad & 64'd1) != 0) begin
            t = (SAMPLES_PER_PERIOD - r) * Q30_HALF_PI / SAMPLES_PER_PERIOD;
         end else begin
            t = r * Q30_HALF_PI / SAMPLES_PER_PERIOD;
         end
         t2 = (t * t) >> 30;
         h  = Q30_ONE;
         h  = Q30_ONE - ((t2 * h) >> 30) / 110;
         h  = Q30_ONE - ((t2 * h) >> 30) / 72;
         h  = Q30_ONE - ((t2 * h) >> 30) / 42;
         h  = Q30_ONE - ((t2 * h) >> 30) / 20;
         h  = Q30_ONE - ((t2 * h) >> 30) / 6;
         s  = (((t * h) >> 30) + 64'd16384) >> 15;
         if (s > SINE_MAX) begin
            s = SINE_MAX;
         end
         if ((quad & 64'd2) != 0) begin
            sine_offset = tmwg_pkg::SINE_W'(SINE_MID - s);
         end else begin
            sine_offset = tmwg_pkg::SINE_W'(SINE_MID + s);
         end
      end
   endfunction

   logic [tmwg_pkg::SINE_W-1:0] rom_table [SAMPLES_PER_PERIOD];
   logic [tmwg_pkg::SINE_W-1:0] data_ff;

   // Fill the constant table
   for (genvar g = 0; g < SAMPLES_PER_PERIOD; g++) begin : g_rom
      assign rom_table[g] = sine_offset(g);
   end

   // Registered read
   always_ff @(posedge clock) begin
      data_ff <= rom_table[addr[AW-1:0]];
   end

   assign data = data_ff;

endmodule

`default_nettype wire

>>> rtl/three_mode_waveform_generator.sv
// Three-mode waveform generator: square pulse, sine and triangle DAC samples.
// Request channel (req_chan): each accepted request is one sample tick; restart
// set to 1 puts the phase index back to zero before this sample.
// Result channel (rsp_chan): one result per request with the 12-bit DAC code,
// the phase index of the sample and a flag on the last sample of the period.
// Configuration port (APB style, pready always high): wave_mode at 0x0,
// amplitude_code at 0x4, duty_percent at 0x8; write only while the block is idle.
// A square or sine sample passes the states S_ROM, S_MUL and S_EVAL and is
// loaded into the output register in S_OUT; a triangle sample also runs
// through S_DIV, the 12 steps of the restoring divider that forms the slope
// quotient one bit per cycle. The next request is taken only once the result
// is in the output register and the sequencer is back in idle.
// The output register holds a result while the receiver stalls; a request
// can already be accepted then, and its result waits until the register is free.
// Reset (synchronous, active high) clears the phase index to zero, empties
// the output register and loads the register defaults: square mode,
// amplitude 3722, duty 50 percent.
`default_nettype none

module three_mode_waveform_generator #(
   parameter int SAMPLES_PER_PERIOD = tmwg_pkg::SAMPLES_PER_PERIOD_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   tmwg_req_if.sink                               req_chan,
   tmwg_rsp_if.source                             rsp_chan,
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [tmwg_pkg::CSR_ADDR_W-1:0]   paddr,
   input  wire logic [tmwg_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic      [tmwg_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                                   pready
);

   localparam int PW    = $clog2(SAMPLES_PER_PERIOD);
   localparam int CW    = $clog2(SAMPLES_PER_PERIOD + 1);
   localparam int DW    = CW + 1;
   localparam int BW    = (CW > tmwg_pkg::SINE_W) ? CW : tmwg_pkg::SINE_W;
   localparam int PRODW = tmwg_pkg::AMP_W + BW;
   localparam int QW    = tmwg_pkg::QUO_W;
   localparam int CNTW  = $clog2(QW);
   localparam int AW    = tmwg_pkg::AMP_W;
   localparam int Pct   = tmwg_pkg::DUTY_MAX;

   localparam logic [PW-1:0]   LAST_IDX  = PW'(SAMPLES_PER_PERIOD - 1);
   localparam logic [CW-1:0]   N_COUNT   = CW'(SAMPLES_PER_PERIOD);
   localparam logic [CNTW-1:0] LAST_STEP = CNTW'(QW - 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_ROM,
      S_MUL,
      S_EVAL,
      S_DIV,
      S_OUT
   } state_type;

   // Configuration registers
   logic [tmwg_pkg::MODE_W-1:0] wave_mode_ff;
   logic [AW-1:0]               amplitude_ff;
   logic [tmwg_pkg::DUTY_W-1:0] duty_ff;
   logic                        csr_write;

   // Sequencer and datapath registers
   state_type         state_ff, state_in;
   logic [PW-1:0]     phase_ff, phase_in;
   logic [PW-1:0]     idx_ff, idx_in;
   logic [CW-1:0]     peak_ff, peak_in;
   logic              rise_ff, rise_in;
   logic [PRODW-1:0]  prod_ff, prod_in;
   logic [DW-1:0]     den_ff, den_in;
   logic [DW-1:0]     rem_ff, rem_in;
   logic [QW-1:0]     quo_ff, quo_in;
   logic [CNTW-1:0]   step_ff, step_in;
   logic [AW-1:0]     res_ff, res_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [AW-1:0]     rsp_dac_ff, rsp_dac_in;
   logic [PW-1:0]     rsp_idx_ff, rsp_idx_in;
   logic              rsp_last_ff, rsp_last_in;

   logic [CW-1:0]              peak_tbl [Pct + 1];
   logic [tmwg_pkg::DUTY_W-1:0] duty_eff;
   logic [tmwg_pkg::SINE_W-1:0] rom_data;
   logic [BW-1:0]              mul_b;
   logic [CW-1:0]              fall_count;
   logic [DW:0]                trial;
   logic                       trial_ge;
   logic                       req_take;
   logic                       out_free;

   // Peak index for each duty value: floor(duty * N / 100)
   for (genvar d = 0; d <= Pct; d++) begin : g_peak
      assign peak_tbl[d] = CW'(d * SAMPLES_PER_PERIOD / Pct);
   end

   tmwg_sine_rom #(
      .SAMPLES_PER_PERIOD (SAMPLES_PER_PERIOD)
   ) u_sine_rom (
      .clock (clock),
      .addr  (idx_ff),
      .data  (rom_data)
   );

   // Register writes and reads
   assign csr_write = psel && penable && pwrite;
   assign pready    = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         wave_mode_ff <= tmwg_pkg::WAVE_MODE_RST;
         amplitude_ff <= tmwg_pkg::AMPLITUDE_RST;
         duty_ff      <= tmwg_pkg::DUTY_RST;
      end else if (csr_write) begin
         case (paddr[3:2])
            tmwg_pkg::REG_WAVE_MODE: wave_mode_ff <= pwdata[tmwg_pkg::MODE_W-1:0];
            tmwg_pkg::REG_AMPLITUDE: amplitude_ff <= pwdata[AW-1:0];
            tmwg_pkg::REG_DUTY:      duty_ff      <= pwdata[tmwg_pkg::DUTY_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         tmwg_pkg::REG_WAVE_MODE: prdata = tmwg_pkg::CSR_DATA_W'(wave_mode_ff);
         tmwg_pkg::REG_AMPLITUDE: prdata = tmwg_pkg::CSR_DATA_W'(amplitude_ff);
         tmwg_pkg::REG_DUTY:      prdata = tmwg_pkg::CSR_DATA_W'(duty_ff);
         default:                 prdata = '0;
      endcase
   end

   // Clamp duty above full scale
   assign duty_eff = (duty_ff > tmwg_pkg::DUTY_W'(Pct)) ? tmwg_pkg::DUTY_W'(Pct) : duty_ff;

   assign req_take = req_chan.valid && (state_ff == S_IDLE);
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   // Multiplier operand: sine code, rising count or falling count
   assign fall_count = N_COUNT - CW'(idx_ff);
   always_comb begin
      if (wave_mode_ff == tmwg_pkg::MODE_SINE) begin
         mul_b = BW'(rom_data);
      end else if (rise_ff) begin
         mul_b = BW'(idx_ff);
      end else begin
         mul_b = BW'(fall_count);
      end
   end

   // Shared subtract and compare of the restoring divider
   assign trial    = {rem_ff, quo_ff[QW-1]};
   assign trial_ge = trial >= {1'b0, den_ff};

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      idx_in       = idx_ff;
      peak_in      = peak_ff;
      rise_in      = rise_ff;
      prod_in      = prod_ff;
      den_in       = den_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      step_in      = step_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_dac_in   = rsp_dac_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_last_in  = rsp_last_ff;

      case (state_ff)
         S_IDLE: begin
            // Take the request, resolve the sample index and advance the phase
            if (req_take) begin
               idx_in   = req_chan.restart ? '0 : phase_ff;
               phase_in = (idx_in == LAST_IDX) ? '0 : idx_in + 1'b1;
               peak_in  = peak_tbl[duty_eff];
               state_in = S_ROM;
            end
         end
         S_ROM: begin
            // ROM read in flight; pick the triangle segment
            rise_in  = CW'(idx_ff) < peak_ff;
            state_in = S_MUL;
         end
         S_MUL: begin
            prod_in  = PRODW'(amplitude_ff * mul_b);
            den_in   = rise_ff ? {peak_ff, 1'b0} : {N_COUNT - peak_ff, 1'b0};
            state_in = S_EVAL;
         end
         S_EVAL: begin
            state_in = S_OUT;
            case (wave_mode_ff)
               tmwg_pkg::MODE_SQUARE:
                  res_in = (CW'(idx_ff) <= peak_ff) ? amplitude_ff : '0;
               tmwg_pkg::MODE_SINE:
                  res_in = prod_ff[tmwg_pkg::SINE_W +: AW];
               tmwg_pkg::MODE_TRIANGLE: begin
                  // Quotient fits QW bits, so the high part starts below the divisor
                  rem_in   = DW'(prod_ff >> QW);
                  quo_in   = prod_ff[QW-1:0];
                  step_in  = '0;
                  state_in = S_DIV;
               end
               default:
                  res_in = '0;
            endcase
         end
         S_DIV: begin
            // One quotient bit per cycle
            rem_in  = trial_ge ? DW'(trial - {1'b0, den_ff}) : DW'(trial);
            quo_in  = {quo_ff[QW-2:0], trial_ge};
            step_in = step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               res_in   = AW'(quo_in);
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            // Hold until the output register is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_dac_in   = res_ff;
               rsp_idx_in   = idx_ff;
               rsp_last_in  = idx_ff == LAST_IDX;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff      <= idx_in;
      peak_ff     <= peak_in;
      rise_ff     <= rise_in;
      prod_ff     <= prod_in;
      den_ff      <= den_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      step_ff     <= step_in;
      res_ff      <= res_in;
      rsp_dac_ff  <= rsp_dac_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_last_ff <= rsp_last_in;
   end

   // Channel outputs
   assign req_chan.ready       = state_ff == S_IDLE;
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.dac_code    = rsp_dac_ff;
   assign rsp_chan.phase_index = tmwg_pkg::PHASE_OUT_W'(rsp_idx_ff);
   assign rsp_chan.period_last = rsp_last_ff;

endmodule

`default_nettype wire

>>> rtl/tmwg_checker.sv
`default_nettype none

module tmwg_checker #(
   parameter int SAMPLES_PER_PERIOD = tmwg_pkg::SAMPLES_PER_PERIOD_DEF
) (
   input wire logic                                 clock,
   input wire logic                                 reset,
   input wire logic                                 req_valid,
   input wire logic                                 req_ready,
   input wire logic                                 rsp_valid,
   input wire logic                                 rsp_ready,
   input wire logic [tmwg_pkg::AMP_W-1:0]           rsp_dac_code,
   input wire logic [tmwg_pkg::PHASE_OUT_W-1:0]     rsp_phase_index,
   input wire logic                                 rsp_period_last
);

   localparam logic [tmwg_pkg::PHASE_OUT_W-1:0] LAST_OUT =
      tmwg_pkg::PHASE_OUT_W'(SAMPLES_PER_PERIOD - 1);

   // Stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_dac_code)
         && $stable(rsp_phase_index) && $stable(rsp_period_last))
      else $error("result changed while stalled");

   // Last-of-period flag only on the final index
   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_period_last |-> rsp_phase_index == LAST_OUT)
      else $error("period_last on a wrong phase index");

   // Busy after taking a request
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while a sample is in progress");

   // Reset empties the output and opens the request side
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("bad state after reset");

endmodule

bind three_mode_waveform_generator tmwg_checker #(
   .SAMPLES_PER_PERIOD (SAMPLES_PER_PERIOD)
) u_tmwg_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_dac_code    (rsp_chan.dac_code),
   .rsp_phase_index (rsp_chan.phase_index),
   .rsp_period_last (rsp_chan.period_last)
);

`default_nettype wire

>>> test/tb_top.sv
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint unsigned PERIOD      = tmwg_pkg::SAMPLES_PER_PERIOD_DEF;
   localparam longint unsigned Q30_ONE     = 64'd1073741824;
   localparam longint unsigned Q30_HALF_PI = 64'd1686629713;
   localparam longint unsigned DUTY_CAP    = tmwg_pkg::DUTY_MAX;

   localparam logic [tmwg_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
   localparam logic [1:0]                  REG_UNUSED  = 2'd3;

   localparam int RANDOM_TICKS   = 1600;
   localparam int SETTLE_CYCLES  = 20;    // covers the triangle path
   localparam int WATCHDOG_LIMIT = 2000;

   typedef struct packed {
      logic [tmwg_pkg::AMP_W-1:0]       dac_code;
      logic [tmwg_pkg::PHASE_OUT_W-1:0] phase_index;
      logic                             period_last;
   } dac_sample_type;

   // Mirror of the generator: registers, phase and samples still owed
   class dac_sample_board;
      logic [tmwg_pkg::MODE_W-1:0] wave_mode;
      logic [tmwg_pkg::AMP_W-1:0]  amplitude;
      logic [tmwg_pkg::DUTY_W-1:0] duty;
      longint unsigned             phase;
      dac_sample_type              pending_samples[$];
      int unsigned                 mismatches;

      function new();
         wave_mode  = tmwg_pkg::WAVE_MODE_RST;
         amplitude  = tmwg_pkg::AMPLITUDE_RST;
         duty       = tmwg_pkg::DUTY_RST;
         phase      = 0;
         mismatches = 0;
      endfunction

      function void set_register(logic [1:0] index, logic [31:0] value);
         case (index)
            tmwg_pkg::REG_WAVE_MODE: wave_mode = value[tmwg_pkg::MODE_W-1:0];
            tmwg_pkg::REG_AMPLITUDE: amplitude = value[tmwg_pkg::AMP_W-1:0];
            tmwg_pkg::REG_DUTY:      duty      = value[tmwg_pkg::DUTY_W-1:0];
            default:                 ;
         endcase
      endfunction

      // Taylor series of sin over the first quadrant, Q30 in and out
      function longint unsigned sin_q30(longint unsigned t);
         longint unsigned t2;
         longint unsigned h;
         longint unsigned divs [5];
         divs = '{110, 72, 42, 20, 6};
         t2 = (t * t) >> 30;
         h = Q30_ONE;
         for (int k = 0; k < 5; k++) begin
            h = Q30_ONE - ((t2 * h) >> 30) / divs[k];
         end
         return (t * h) >> 30;
      endfunction

      // Q1.15 sine table entry, folded from the first quadrant
      function int sine_q15(longint unsigned idx);
         longint unsigned q, quad, r, t, s;
         int v;
         q = idx * 4;
         quad = q / PERIOD;
         r = q % PERIOD;
         if (quad[0]) begin
            t = (PERIOD - r) * Q30_HALF_PI / PERIOD;
         end else begin
            t = r * Q30_HALF_PI / PERIOD;
         end
         s = (sin_q30(t) + 16384) >> 15;
         if (s > 32767) s = 32767;
         v = int'(s);
         return quad[1] ? -v : v;
      endfunction

      function logic [tmwg_pkg::AMP_W-1:0] wave_code(longint unsigned idx);
         longint unsigned amp, eff_duty, peak, lifted, code;
         amp = amplitude;
         eff_duty = (duty > DUTY_CAP) ? DUTY_CAP : duty;
         peak = eff_duty * PERIOD / DUTY_CAP;
         code = 0;
         case (wave_mode)
            tmwg_pkg::MODE_SQUARE: begin
               code = (idx <= peak) ? amp : 0;
            end
            tmwg_pkg::MODE_SINE: begin
               lifted = 32768 + sine_q15(idx);
               code = (amp * lifted) >> 16;
            end
            tmwg_pkg::MODE_TRIANGLE: begin
               if (idx < peak) code = amp * idx / (2 * peak);
               else code = amp * (PERIOD - idx) / (2 * (PERIOD - peak));
            end
            default: code = 0;
         endcase
         return code[tmwg_pkg::AMP_W-1:0];
      endfunction

      // Advance the phase and queue the sample this request produces
      function void note_tick(logic restart);
         dac_sample_type s;
         longint unsigned idx;
         if (restart || phase >= PERIOD) phase = 0;
         idx = phase;
         s.dac_code    = wave_code(idx);
         s.phase_index = idx[tmwg_pkg::PHASE_OUT_W-1:0];
         s.period_last = (idx == PERIOD - 1);
         pending_samples.push_back(s);
         phase = (idx + 1 >= PERIOD) ? 0 : idx + 1;
      endfunction

      function int pending_count();
         return pending_samples.size();
      endfunction

      function void flag(string field, logic [31:0] want, logic [31:0] got);
         mismatches++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      endfunction

      function void check_sample(logic [tmwg_pkg::AMP_W-1:0] dac,
                                 logic [tmwg_pkg::PHASE_OUT_W-1:0] idx, logic last);
         dac_sample_type want;
         if (pending_samples.size() == 0) begin
            mismatches++;
            $display("%0t: sample with none expected, dac_code %0d phase_index %0d",
                     $time, dac, idx);
            return;
         end
         want = pending_samples.pop_front();
         if (dac !== want.dac_code) flag("dac_code", want.dac_code, dac);
         if (idx !== want.phase_index) flag("phase_index", want.phase_index, idx);
         if (last !== want.period_last) flag("period_last", want.period_last, last);
      endfunction
   endclass

   logic                            clock;
   logic                            reset;
   logic                            psel;
   logic                            penable;
   logic                            pwrite;
   logic [tmwg_pkg::CSR_ADDR_W-1:0] paddr;
   logic [tmwg_pkg::CSR_DATA_W-1:0] pwdata;
   logic [tmwg_pkg::CSR_DATA_W-1:0] prdata;
   logic                            pready;

   tmwg_req_if req_if ();
   tmwg_rsp_if rsp_if ();

   dac_sample_board board;
   bit              sender_calm;
   int              ticks_sent;
   int              idle_cycles = 0;

   three_mode_waveform_generator i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // Fill the unused upper bits of a register write with noise
   function automatic logic [31:0] noisy(logic [31:0] value, int width);
      logic [31:0] upper;
      upper = $urandom();
      return (upper << width) | value;
   endfunction

   task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      board.set_register(index, value);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // Offer one request and hold it until the block takes it
   task automatic send_tick(input logic restart);
      int gap;
      gap = sender_calm ? 0 : pick_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.restart <= restart;
      do @(posedge clock); while (!req_if.ready);
      board.note_tick(restart);
      ticks_sent++;
   endtask

   // restart_odds 0: restart only on the first request if asked; else also one in restart_odds
   task automatic send_burst(input int count, input bit restart_first, input int restart_odds);
      logic restart;
      for (int k = 0; k < count; k++) begin
         restart = (k == 0) && restart_first;
         if (restart_odds > 0 && $urandom_range(1, restart_odds) == 1) restart = 1'b1;
         send_tick(restart);
      end
      req_if.valid <= 1'b0;
   endtask

   // Drain every owed sample, then let the datapath settle
   task automatic wait_idle();
      while (board.pending_count() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic shuffle_registers();
      logic [tmwg_pkg::MODE_W-1:0] mode;
      logic [tmwg_pkg::AMP_W-1:0]  amp;
      logic [tmwg_pkg::DUTY_W-1:0] duty;
      int unsigned                 pick;
      if ($urandom_range(0, 7) == 0) write_reg(REG_UNUSED, $urandom());
      if ($urandom_range(0, 3) != 0) begin
         pick = $urandom_range(0, 9);
         mode = (pick < 3) ? tmwg_pkg::MODE_SQUARE : (pick < 6) ? tmwg_pkg::MODE_SINE :
                (pick < 9) ? tmwg_pkg::MODE_TRIANGLE : MODE_UNUSED;
         write_reg(tmwg_pkg::REG_WAVE_MODE, noisy(32'(mode), tmwg_pkg::MODE_W));
      end
      if ($urandom_range(0, 2) != 0) begin
         pick = $urandom_range(0, 5);
         amp = (pick == 0) ? '0 : (pick == 1) ? '1 : tmwg_pkg::AMP_W'($urandom());
         write_reg(tmwg_pkg::REG_AMPLITUDE, noisy(32'(amp), tmwg_pkg::AMP_W));
      end
      if ($urandom_range(0, 2) != 0) begin
         pick = $urandom_range(0, 7);
         duty = (pick == 0) ? 7'd0 : (pick == 1) ? 7'(tmwg_pkg::DUTY_MAX) :
                (pick == 2) ? 7'($urandom_range(tmwg_pkg::DUTY_MAX + 1, 127)) :
                7'($urandom_range(0, tmwg_pkg::DUTY_MAX));
         write_reg(tmwg_pkg::REG_DUTY, noisy(32'(duty), tmwg_pkg::DUTY_W));
      end
   endtask

   // Receiver: runs of ready, broken by stalls of random length
   initial begin
      int run;
      int stall;
      forever begin
         run = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
         rsp_if.ready <= 1'b1;
         repeat (run) @(posedge clock);
         stall = pick_gap();
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   // Check each sample the receiver takes
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready)
         board.check_sample(rsp_if.dac_code, rsp_if.phase_index, rsp_if.period_last);
   end

   // Abort when nothing moves for too long
   always @(posedge clock) begin
      if (reset || psel || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL three_mode_waveform_generator");
         $finish;
      end
   end

   initial begin
      int target;
      int pick;
      int odds;
      int count;
      board          = new();
      sender_calm    = 1'b0;
      ticks_sent     = 0;
      reset          <= 1'b1;
      psel           <= 1'b0;
      penable        <= 1'b0;
      pwrite         <= 1'b0;
      paddr          <= '0;
      pwdata         <= '0;
      req_if.valid   <= 1'b0;
      req_if.restart <= 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Register defaults: square, half duty
      send_burst(4, 1'b1, 0);
      wait_idle();

      // Sine at full scale, written with noise in the upper bits; duty zero
      write_reg(tmwg_pkg::REG_WAVE_MODE, noisy(32'(tmwg_pkg::MODE_SINE), tmwg_pkg::MODE_W));
      write_reg(tmwg_pkg::REG_AMPLITUDE, 32'hFFFF_FFFF);
      write_reg(tmwg_pkg::REG_DUTY, noisy(32'd0, tmwg_pkg::DUTY_W));
      send_burst(4, 1'b0, 0);
      wait_idle();

      // Triangle with duty above range, which acts as full duty
      write_reg(tmwg_pkg::REG_WAVE_MODE,
                noisy(32'(tmwg_pkg::MODE_TRIANGLE), tmwg_pkg::MODE_W));
      write_reg(tmwg_pkg::REG_DUTY, 32'hFFFF_FF7F);
      send_burst(4, 1'b1, 0);
      wait_idle();

      // Write off the register map is dropped; triangle that only falls
      write_reg(REG_UNUSED, 32'hFFFF_FFFF);
      write_reg(tmwg_pkg::REG_DUTY, 32'd0);
      send_burst(4, 1'b0, 2);
      wait_idle();

      // Unused mode gives zero while the phase keeps going
      write_reg(tmwg_pkg::REG_WAVE_MODE, 32'hFFFF_FFFF);
      write_reg(tmwg_pkg::REG_AMPLITUDE, noisy(32'd0, tmwg_pkg::AMP_W));
      send_burst(3, 1'b0, 0);
      wait_idle();

      // Square high over the whole period at the smallest step
      write_reg(tmwg_pkg::REG_WAVE_MODE, 32'(tmwg_pkg::MODE_SQUARE));
      write_reg(tmwg_pkg::REG_DUTY, 32'(tmwg_pkg::DUTY_MAX));
      write_reg(tmwg_pkg::REG_AMPLITUDE, 32'd1);
      send_burst(4, 1'b1, 0);

      // Random phases: long runs let the phase wrap, a few are restart noise
      target = ticks_sent + RANDOM_TICKS;
      while (ticks_sent < target) begin
         wait_idle();
         shuffle_registers();
         sender_calm = ($urandom_range(0, 3) == 0);
         pick = $urandom_range(0, 9);
         odds = (pick < 4) ? 0 : (pick < 8) ? 150 : 3;
         count = $urandom_range(20, 320);
         if (count > target - ticks_sent) count = target - ticks_sent;
         send_burst(count, $urandom_range(0, 1), odds);
      end
      wait_idle();

      if (board.mismatches == 0 && board.pending_count() == 0)
         $display("PASS three_mode_waveform_generator");
      else
         $display("FAIL three_mode_waveform_generator");
      $finish;
   end

endmodule

`default_nettype wire

>>> files.f
rtl/tmwg_pkg.sv
rtl/tmwg_channels.sv
rtl/tmwg_sine_rom.sv
rtl/three_mode_waveform_generator.sv
rtl/tmwg_checker.sv
test/tb_top.sv
